>>> rtl/cubic_bisection_root_finder_core_defines.svh
// Assertion macros used by the checker file of the root finder.
`ifndef CUBIC_BISECTION_ROOT_FINDER_CORE_DEFINES_SVH
`define CUBIC_BISECTION_ROOT_FINDER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/cbrf_pkg.sv
package cbrf_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int MAX_ITER = 64;

   localparam int ITER_BITS = 7;
   localparam int STATUS_BITS = 2;
   localparam int TOL_BITS = WORD_BITS - 1;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int QUOT_BITS = PROD_BITS - FRAC_BITS;
   localparam int REG_INDEX_BITS = 3;
   localparam int OP_BITS = 5;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [OP_BITS-1:0] op_type;

   localparam word_type COEF_CONST_RESET = word_type'(-257219887);
   localparam word_type COEF_LINEAR_RESET = word_type'(983204909);
   localparam word_type COEF_SQUARE_RESET = word_type'(-1245208300);
   localparam word_type COEF_CUBE_RESET = word_type'(519261493);

   localparam logic [REG_INDEX_BITS-1:0] REG_COEF_CONST = 3'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_COEF_LINEAR = 3'd1;
   localparam logic [REG_INDEX_BITS-1:0] REG_COEF_SQUARE = 3'd2;
   localparam logic [REG_INDEX_BITS-1:0] REG_COEF_CUBE = 3'd3;
   localparam logic [REG_INDEX_BITS-1:0] REG_TOLERANCE = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EXACT_ZERO = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_SIGN_CHANGE = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_ITER_LIMIT = 2'd3;

   localparam op_type OP_NONE = 5'd0;
   localparam op_type OP_LOAD = 5'd1;
   localparam op_type OP_SETX_LO = 5'd2;
   localparam op_type OP_SETX_HI = 5'd3;
   localparam op_type OP_SETX_MID = 5'd4;
   localparam op_type OP_MUL = 5'd5;
   localparam op_type OP_SAT = 5'd6;
   localparam op_type OP_ADD_SQUARE = 5'd7;
   localparam op_type OP_ADD_LINEAR = 5'd8;
   localparam op_type OP_ADD_CONST = 5'd9;
   localparam op_type OP_SAVE_FA = 5'd10;
   localparam op_type OP_SAVE_FB = 5'd11;
   localparam op_type OP_NO_SIGN = 5'd12;
   localparam op_type OP_FIRST = 5'd13;
   localparam op_type OP_HALVE = 5'd14;
   localparam op_type OP_ERR = 5'd15;
   localparam op_type OP_TEST = 5'd16;
   localparam op_type OP_BISECT = 5'd17;
   localparam op_type OP_EMIT = 5'd18;

   typedef struct packed {
      logic no_sign;
      logic no_split;
      logic stop;
      logic out_busy;
   } flags_type;

   function automatic logic cbrf_opposite(input word_type p, input word_type q);
      logic p_neg;
      logic p_pos;
      logic q_neg;
      logic q_pos;
      p_neg = p[WORD_BITS-1];
      p_pos = !p[WORD_BITS-1] && (|p);
      q_neg = q[WORD_BITS-1];
      q_pos = !q[WORD_BITS-1] && (|q);
      return (p_neg && q_pos) || (p_pos && q_neg);
   endfunction

endpackage

>>> rtl/cbrf_if.sv
interface cbrf_req_if import cbrf_pkg::*; ();
   logic valid;
   logic ready;
   word_type interval_low;
   word_type interval_high;

   modport source (output valid, output interval_low, output interval_high, input ready);
   modport sink (input valid, input interval_low, input interval_high, output ready);
endinterface

interface cbrf_rsp_if import cbrf_pkg::*; ();
   logic valid;
   logic ready;
   word_type root;
   logic [WORD_BITS-1:0] approx_error;
   logic [ITER_BITS-1:0] iterations;
   logic [STATUS_BITS-1:0] status;

   modport source (output valid, output root, output approx_error, output iterations,
                   output status, input ready);
   modport sink (input valid, input root, input approx_error, input iterations,
                 input status, output ready);
endinterface

>>> rtl/cubic_bisection_root_finder_core.sv
// Cubic root finder by bisection over a signed fixed-point interval.
// A request transaction carries interval_low and interval_high; each one
// produces exactly one response transaction with root, approx_error,
// iterations and status. The four coefficients and the tolerance must be
// written through the csr port while the block is idle; nothing enforces it.
// One request is worked on at a time. The polynomial is evaluated by a shared
// multiply, saturate and add datapath, which sets the pace of the search.
// After a response is registered, the block steps through a restart state
// back to its wait state and is ready for the next request, even if that
// response has not been taken yet. A stalled receiver holds the response
// stable and keeps the search from finishing the following one.
// Reset restores the coefficient and tolerance defaults and empties the
// response register.
module cubic_bisection_root_finder_core import cbrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   cbrf_req_if.sink                  req_bus,
   cbrf_rsp_if.source                rsp_bus,
   input  logic                      csr_we,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata
);

   op_type op;
   flags_type flags;

   cbrf_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .flags     (flags),
      .op        (op),
      .req_ready (req_bus.ready)
   );

   cbrf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_valid         (req_bus.valid),
      .req_interval_low  (req_bus.interval_low),
      .req_interval_high (req_bus.interval_high),
      .rsp_ready         (rsp_bus.ready),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .flags             (flags),
      .rsp_valid         (rsp_bus.valid),
      .rsp_root          (rsp_bus.root),
      .rsp_approx_error  (rsp_bus.approx_error),
      .rsp_iterations    (rsp_bus.iterations),
      .rsp_status        (rsp_bus.status)
   );

endmodule

>>> rtl/cbrf_sequencer.sv
module cbrf_sequencer import cbrf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  flags_type flags,
   output op_type    op,
   output logic      req_ready
);

   localparam int PC_BITS = 5;
   localparam int COND_BITS = 4;

   typedef logic [PC_BITS-1:0] pc_type;
   typedef logic [COND_BITS-1:0] cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   localparam cond_type COND_NEXT = 4'd0;
   localparam cond_type COND_ALWAYS = 4'd1;
   localparam cond_type COND_CALL = 4'd2;
   localparam cond_type COND_RETURN = 4'd3;
   localparam cond_type COND_NO_REQ = 4'd4;
   localparam cond_type COND_NO_SIGN = 4'd5;
   localparam cond_type COND_NO_SPLIT = 4'd6;
   localparam cond_type COND_STOP = 4'd7;
   localparam cond_type COND_OUT_BUSY = 4'd8;

   localparam pc_type ADDR_WAIT = 5'd0;
   localparam pc_type ADDR_EVAL_LO = 5'd1;
   localparam pc_type ADDR_SAVE_FA = 5'd2;
   localparam pc_type ADDR_EVAL_HI = 5'd3;
   localparam pc_type ADDR_SAVE_FB = 5'd4;
   localparam pc_type ADDR_SIGN = 5'd5;
   localparam pc_type ADDR_FIRST = 5'd6;
   localparam pc_type ADDR_ERR = 5'd7;
   localparam pc_type ADDR_TEST = 5'd8;
   localparam pc_type ADDR_EVAL_MID = 5'd9;
   localparam pc_type ADDR_BISECT = 5'd10;
   localparam pc_type ADDR_HALVE = 5'd11;
   localparam pc_type ADDR_EMIT = 5'd12;
   localparam pc_type ADDR_RESTART = 5'd13;
   localparam pc_type ADDR_POLY = 5'd14;

   function automatic uword_type ucode(input pc_type addr);
      uword_type w;
      w = '{OP_NONE, COND_ALWAYS, ADDR_WAIT};
      unique case (addr)
         ADDR_WAIT:     w = '{OP_LOAD, COND_NO_REQ, ADDR_WAIT};
         ADDR_EVAL_LO:  w = '{OP_SETX_LO, COND_CALL, ADDR_POLY};
         ADDR_SAVE_FA:  w = '{OP_SAVE_FA, COND_NEXT, ADDR_WAIT};
         ADDR_EVAL_HI:  w = '{OP_SETX_HI, COND_CALL, ADDR_POLY};
         ADDR_SAVE_FB:  w = '{OP_SAVE_FB, COND_NEXT, ADDR_WAIT};
         ADDR_SIGN:     w = '{OP_NO_SIGN, COND_NO_SIGN, ADDR_EMIT};
         ADDR_FIRST:    w = '{OP_FIRST, COND_NEXT, ADDR_WAIT};
         ADDR_ERR:      w = '{OP_ERR, COND_NEXT, ADDR_WAIT};
         ADDR_TEST:     w = '{OP_TEST, COND_STOP, ADDR_EMIT};
         ADDR_EVAL_MID: w = '{OP_SETX_MID, COND_CALL, ADDR_POLY};
         ADDR_BISECT:   w = '{OP_BISECT, COND_NO_SPLIT, ADDR_EMIT};
         ADDR_HALVE:    w = '{OP_HALVE, COND_ALWAYS, ADDR_ERR};
         ADDR_EMIT:     w = '{OP_EMIT, COND_OUT_BUSY, ADDR_EMIT};
         ADDR_RESTART:  w = '{OP_NONE, COND_ALWAYS, ADDR_WAIT};
         ADDR_POLY:                    w = '{OP_MUL, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(1):      w = '{OP_SAT, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(2):      w = '{OP_ADD_SQUARE, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(3):      w = '{OP_MUL, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(4):      w = '{OP_SAT, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(5):      w = '{OP_ADD_LINEAR, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(6):      w = '{OP_MUL, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(7):      w = '{OP_SAT, COND_NEXT, ADDR_WAIT};
         ADDR_POLY + PC_BITS'(8):      w = '{OP_ADD_CONST, COND_RETURN, ADDR_WAIT};
         default: ;
      endcase
      return w;
   endfunction

   pc_type pc_ff;
   pc_type pc_in;
   pc_type ret_ff;
   pc_type ret_in;
   uword_type word;
   logic take;

   always_comb begin
      word = ucode(pc_ff);
      unique case (word.cond)
         COND_NEXT:     take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_CALL:     take = 1'b1;
         COND_RETURN:   take = 1'b1;
         COND_NO_REQ:   take = !req_valid;
         COND_NO_SIGN:  take = flags.no_sign;
         COND_NO_SPLIT: take = flags.no_split;
         COND_STOP:     take = flags.stop;
         COND_OUT_BUSY: take = flags.out_busy;
         default:       take = 1'b1;
      endcase
      ret_in = ret_ff;
      if (word.cond == COND_CALL) begin
         ret_in = pc_ff + PC_BITS'(1);
      end
      if (!take) begin
         pc_in = pc_ff + PC_BITS'(1);
      end else if (word.cond == COND_RETURN) begin
         pc_in = ret_ff;
      end else begin
         pc_in = word.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ADDR_WAIT;
         ret_ff <= ADDR_WAIT;
      end else begin
         pc_ff <= pc_in;
         ret_ff <= ret_in;
      end
   end

   assign op = word.op;
   assign req_ready = (pc_ff == ADDR_WAIT);

endmodule

>>> rtl/cbrf_datapath.sv
module cbrf_datapath import cbrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  op_type                    op,
   input  logic                      req_valid,
   input  word_type                  req_interval_low,
   input  word_type                  req_interval_high,
   input  logic                      rsp_ready,
   input  logic                      csr_we,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata,
   output flags_type                 flags,
   output logic                      rsp_valid,
   output word_type                  rsp_root,
   output logic [WORD_BITS-1:0]      rsp_approx_error,
   output logic [ITER_BITS-1:0]      rsp_iterations,
   output logic [STATUS_BITS-1:0]    rsp_status
);

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [PROD_BITS-1:0] TRUNC_BIAS =
      {{(PROD_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   word_type coef_const_ff, coef_const_in;
   word_type coef_linear_ff, coef_linear_in;
   word_type coef_square_ff, coef_square_in;
   word_type coef_cube_ff, coef_cube_in;
   logic [TOL_BITS-1:0] tolerance_ff, tolerance_in;

   word_type lo_ff, lo_in;
   word_type hi_ff, hi_in;
   word_type x_ff, x_in;
   word_type acc_ff, acc_in;
   word_type term_ff, term_in;
   word_type fa_ff, fa_in;
   word_type fb_ff, fb_in;
   word_type mid_ff, mid_in;
   word_type prev_ff, prev_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic [WORD_BITS-1:0] err_ff, err_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic rsp_valid_ff, rsp_valid_in;
   word_type rsp_root_ff, rsp_root_in;
   logic [WORD_BITS-1:0] rsp_err_ff, rsp_err_in;
   logic [ITER_BITS-1:0] rsp_iter_ff, rsp_iter_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic signed [PROD_BITS-1:0] acc_wide;
   logic signed [PROD_BITS-1:0] x_wide;
   logic [PROD_BITS-1:0] prod_adj;
   logic [QUOT_BITS-1:0] quot;
   logic [QUOT_BITS-WORD_BITS:0] quot_upper;
   word_type term_sat;
   word_type addend;
   logic [WORD_BITS:0] sum_term;
   word_type sum_sat;
   logic [WORD_BITS:0] sum_ends;
   word_type half;
   logic [WORD_BITS:0] diff;
   logic [WORD_BITS:0] diff_abs;
   logic err_le_tol;
   logic out_busy;

   always_comb begin
      acc_wide = acc_ff;
      x_wide = x_ff;
      prod_adj = prod_ff + (prod_ff[PROD_BITS-1] ? TRUNC_BIAS : '0);
      quot = prod_adj[PROD_BITS-1:FRAC_BITS];
      quot_upper = quot[QUOT_BITS-1:WORD_BITS-1];
      if ((&quot_upper) || !(|quot_upper)) begin
         term_sat = quot[WORD_BITS-1:0];
      end else begin
         term_sat = quot[QUOT_BITS-1] ? WORD_MIN : WORD_MAX;
      end

      priority case (op)
         OP_ADD_SQUARE: addend = coef_square_ff;
         OP_ADD_LINEAR: addend = coef_linear_ff;
         default:       addend = coef_const_ff;
      endcase
      sum_term = {term_ff[WORD_BITS-1], term_ff} + {addend[WORD_BITS-1], addend};
      if (sum_term[WORD_BITS] != sum_term[WORD_BITS-1]) begin
         sum_sat = sum_term[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end else begin
         sum_sat = sum_term[WORD_BITS-1:0];
      end

      sum_ends = {lo_ff[WORD_BITS-1], lo_ff} + {hi_ff[WORD_BITS-1], hi_ff};
      half = sum_ends[WORD_BITS:1];
      diff = {mid_ff[WORD_BITS-1], mid_ff} - {prev_ff[WORD_BITS-1], prev_ff};
      diff_abs = diff[WORD_BITS] ? -diff : diff;
      err_le_tol = (err_ff <= {1'b0, tolerance_ff});
      out_busy = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      coef_const_in = coef_const_ff;
      coef_linear_in = coef_linear_ff;
      coef_square_in = coef_square_ff;
      coef_cube_in = coef_cube_ff;
      tolerance_in = tolerance_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      term_in = term_ff;
      fa_in = fa_ff;
      fb_in = fb_ff;
      mid_in = mid_ff;
      prev_in = prev_ff;
      prod_in = prod_ff;
      err_in = err_ff;
      iter_in = iter_ff;
      status_in = status_ff;
      rsp_valid_in = out_busy;
      rsp_root_in = rsp_root_ff;
      rsp_err_in = rsp_err_ff;
      rsp_iter_in = rsp_iter_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_COEF_CONST:  coef_const_in = csr_wdata;
            REG_COEF_LINEAR: coef_linear_in = csr_wdata;
            REG_COEF_SQUARE: coef_square_in = csr_wdata;
            REG_COEF_CUBE:   coef_cube_in = csr_wdata;
            REG_TOLERANCE:   tolerance_in = csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end

      unique case (op)
         OP_LOAD: begin
            if (req_valid) begin
               lo_in = req_interval_low;
               hi_in = req_interval_high;
               mid_in = '0;
               err_in = '0;
               iter_in = '0;
            end
         end
         OP_SETX_LO: begin
            x_in = lo_ff;
            acc_in = coef_cube_ff;
         end
         OP_SETX_HI: begin
            x_in = hi_ff;
            acc_in = coef_cube_ff;
         end
         OP_SETX_MID: begin
            x_in = mid_ff;
            acc_in = coef_cube_ff;
         end
         OP_MUL:        prod_in = acc_wide * x_wide;
         OP_SAT:        term_in = term_sat;
         OP_ADD_SQUARE: acc_in = sum_sat;
         OP_ADD_LINEAR: acc_in = sum_sat;
         OP_ADD_CONST:  acc_in = sum_sat;
         OP_SAVE_FA:    fa_in = acc_ff;
         OP_SAVE_FB:    fb_in = acc_ff;
         OP_NO_SIGN:    status_in = STATUS_NO_SIGN_CHANGE;
         OP_FIRST: begin
            mid_in = half;
            prev_in = lo_ff;
            iter_in = iter_ff + ITER_BITS'(1);
         end
         OP_HALVE: begin
            mid_in = half;
            iter_in = iter_ff + ITER_BITS'(1);
         end
         OP_ERR:        err_in = diff_abs[WORD_BITS-1:0];
         OP_TEST:       status_in = err_le_tol ? STATUS_CONVERGED : STATUS_ITER_LIMIT;
         OP_BISECT: begin
            if (cbrf_opposite(fa_ff, acc_ff)) begin
               hi_in = mid_ff;
               fb_in = acc_ff;
               prev_in = mid_ff;
            end else if (cbrf_opposite(fb_ff, acc_ff)) begin
               lo_in = mid_ff;
               fa_in = acc_ff;
               prev_in = mid_ff;
            end else begin
               status_in = STATUS_EXACT_ZERO;
            end
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_root_in = mid_ff;
               rsp_err_in = err_ff;
               rsp_iter_in = iter_ff;
               rsp_status_in = status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_const_ff <= COEF_CONST_RESET;
         coef_linear_ff <= COEF_LINEAR_RESET;
         coef_square_ff <= COEF_SQUARE_RESET;
         coef_cube_ff <= COEF_CUBE_RESET;
         tolerance_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_const_ff <= coef_const_in;
         coef_linear_ff <= coef_linear_in;
         coef_square_ff <= coef_square_in;
         coef_cube_ff <= coef_cube_in;
         tolerance_ff <= tolerance_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      term_ff <= term_in;
      fa_ff <= fa_in;
      fb_ff <= fb_in;
      mid_ff <= mid_in;
      prev_ff <= prev_in;
      prod_ff <= prod_in;
      err_ff <= err_in;
      iter_ff <= iter_in;
      status_ff <= status_in;
      rsp_root_ff <= rsp_root_in;
      rsp_err_ff <= rsp_err_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign flags.no_sign = !cbrf_opposite(fa_ff, fb_ff);
   assign flags.no_split = !cbrf_opposite(fa_ff, acc_ff) && !cbrf_opposite(fb_ff, acc_ff);
   assign flags.stop = err_le_tol || (iter_ff >= ITER_BITS'(MAX_ITER));
   assign flags.out_busy = out_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root = rsp_root_ff;
   assign rsp_approx_error = rsp_err_ff;
   assign rsp_iterations = rsp_iter_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> rtl/cbrf_checker.sv
`include "cubic_bisection_root_finder_core_defines.svh"

module cbrf_checker import cbrf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input word_type               rsp_root,
   input logic [WORD_BITS-1:0]   rsp_approx_error,
   input logic [ITER_BITS-1:0]   rsp_iterations,
   input logic [STATUS_BITS-1:0] rsp_status
);

   logic [2*WORD_BITS+ITER_BITS+STATUS_BITS-1:0] rsp_payload;
   logic rsp_stall;
   logic req_take;
   logic rsp_no_sign;
   logic rsp_empty;

   assign rsp_payload = {rsp_root, rsp_approx_error, rsp_iterations, rsp_status};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_take = req_valid && req_ready;
   assign rsp_no_sign = rsp_valid && (rsp_status == STATUS_NO_SIGN_CHANGE);
   assign rsp_empty = (rsp_root == '0) && (rsp_approx_error == '0) && (rsp_iterations == '0);

   `CBRF_ASSERT_NOW(a_reset_empties_rsp, $past(reset), !rsp_valid, "response valid after reset")
   `CBRF_ASSERT_NEXT(a_rsp_held, rsp_stall, rsp_valid, "stalled response dropped")
   `CBRF_ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable(rsp_payload), "stalled response changed")
   `CBRF_ASSERT_NEXT(a_one_request, req_take, !req_ready, "second request taken while busy")
   `CBRF_ASSERT_NOW(a_no_sign_empty, rsp_no_sign, rsp_empty, "no sign change response not empty")

endmodule

bind cubic_bisection_root_finder_core cbrf_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_root         (rsp_bus.root),
   .rsp_approx_error (rsp_bus.approx_error),
   .rsp_iterations   (rsp_bus.iterations),
   .rsp_status       (rsp_bus.status)
);

>>> dv/cbrf_root_checker.sv
module cbrf_root_checker import cbrf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   cbrf_req_if                       req_bus,
   cbrf_rsp_if                       rsp_bus,
   input  logic                      csr_we,
   input  logic [REG_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   typedef struct {
      word_type                root;
      logic [WORD_BITS-1:0]    approx_error;
      logic [ITER_BITS-1:0]    iterations;
      logic [STATUS_BITS-1:0]  status;
   } root_report_type;

   localparam longint WORD_HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint WORD_LO = -(longint'(1) <<< (WORD_BITS - 1));

   word_type              coef_const_q;
   word_type              coef_linear_q;
   word_type              coef_square_q;
   word_type              coef_cube_q;
   logic [TOL_BITS-1:0]   tol_q;

   root_report_type awaited_roots[$];
   int mismatches = 0;
   int outstanding = 0;

   assign fail_count = mismatches;
   assign pending = outstanding;

   function automatic longint clamp_word(longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   function automatic longint fixed_product(longint a, longint b);
      longint prod;
      longint mag;
      longint lim;
      logic neg;
      prod = a * b;
      neg = prod < 0;
      mag = neg ? -prod : prod;
      mag = mag >> FRAC_BITS;
      lim = neg ? -WORD_LO : WORD_HI;
      if (mag > lim) mag = lim;
      return neg ? -mag : mag;
   endfunction

   function automatic longint cubic_value(longint x);
      longint acc;
      acc = longint'(coef_cube_q);
      acc = clamp_word(fixed_product(acc, x) + longint'(coef_square_q));
      acc = clamp_word(fixed_product(acc, x) + longint'(coef_linear_q));
      acc = clamp_word(fixed_product(acc, x) + longint'(coef_const_q));
      return acc;
   endfunction

   function automatic logic signs_differ(longint p, longint q);
      return (p < 0 && q > 0) || (p > 0 && q < 0);
   endfunction

   function automatic root_report_type solve_interval(word_type lo_w, word_type hi_w);
      root_report_type report;
      longint a;
      longint b;
      longint cn;
      longint cv;
      longint fc;
      longint err;
      int iter;
      logic [STATUS_BITS-1:0] st;
      logic done;
      a = longint'(lo_w);
      b = longint'(hi_w);
      cn = 0;
      cv = 0;
      err = 0;
      iter = 0;
      if (!signs_differ(cubic_value(a), cubic_value(b))) begin
         st = STATUS_NO_SIGN_CHANGE;
      end else begin
         st = STATUS_ITER_LIMIT;
         done = 1'b0;
         while (!done) begin
            if (iter == 0) begin
               cn = (a + b) >>> 1;
               cv = a;
            end else begin
               fc = cubic_value(cn);
               if (signs_differ(cubic_value(a), fc)) begin
                  b = cn;
               end else if (signs_differ(cubic_value(b), fc)) begin
                  a = cn;
               end else begin
                  st = STATUS_EXACT_ZERO;
                  done = 1'b1;
               end
               if (!done) begin
                  cv = cn;
                  cn = (a + b) >>> 1;
               end
            end
            if (!done) begin
               err = (cn > cv) ? cn - cv : cv - cn;
               iter++;
               if (err <= longint'(tol_q)) begin
                  st = STATUS_CONVERGED;
                  done = 1'b1;
               end else if (iter >= MAX_ITER) begin
                  done = 1'b1;
               end
            end
         end
      end
      report.root = word_type'(cn);
      report.approx_error = err[WORD_BITS-1:0];
      report.iterations = iter[ITER_BITS-1:0];
      report.status = st;
      return report;
   endfunction

   task automatic compare_field(string field, logic [WORD_BITS-1:0] expected,
                                logic [WORD_BITS-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected 0x%h actual 0x%h", $time, field, expected,
                  actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      root_report_type want;
      if (reset) begin
         coef_const_q = COEF_CONST_RESET;
         coef_linear_q = COEF_LINEAR_RESET;
         coef_square_q = COEF_SQUARE_RESET;
         coef_cube_q = COEF_CUBE_RESET;
         tol_q = '0;
         awaited_roots.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_COEF_CONST: coef_const_q = csr_wdata;
               REG_COEF_LINEAR: coef_linear_q = csr_wdata;
               REG_COEF_SQUARE: coef_square_q = csr_wdata;
               REG_COEF_CUBE: coef_cube_q = csr_wdata;
               REG_TOLERANCE: tol_q = csr_wdata[TOL_BITS-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            awaited_roots.push_back(solve_interval(req_bus.interval_low,
                                                   req_bus.interval_high));
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (awaited_roots.size() == 0) begin
               $display("%0t: response transaction with none expected, expected none actual 0x%h",
                        $time, rsp_bus.root);
               mismatches++;
            end else begin
               want = awaited_roots.pop_front();
               compare_field("root", want.root, rsp_bus.root);
               compare_field("approx_error", want.approx_error, rsp_bus.approx_error);
               compare_field("iterations", want.iterations, rsp_bus.iterations);
               compare_field("status", want.status, rsp_bus.status);
            end
         end
      end
      outstanding <= awaited_roots.size();
   end

endmodule

>>> dv/tb.sv
module tb;
   import cbrf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1280;
   localparam int QUIET_TAIL = 160;
   localparam int LONG_HOLD = 3000;
   localparam int HOLD_PHASE = 3;
   localparam longint UNIT = longint'(1) <<< FRAC_BITS;
   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum int {
      SET_LINEAR_ROOT,
      SET_MODERATE,
      SET_WILD,
      SET_DEFAULT
   } setting_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [REG_INDEX_BITS-1:0] csr_index;
   logic [WORD_BITS-1:0] csr_wdata;

   int mismatch_total;
   int awaiting;

   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int req_gap_odds = 4;
   int rsp_gap_odds = 4;
   longint linear_root = 0;

   cbrf_req_if req_bus ();
   cbrf_rsp_if rsp_bus ();

   cubic_bisection_root_finder_core dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cbrf_root_checker root_monitor (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(mismatch_total),
      .pending(awaiting)
   );

   always #4 clock = ~clock;

   function automatic word_type fit_word(longint v);
      if (v > longint'(WORD_MAX)) return WORD_MAX;
      if (v < longint'(WORD_MIN)) return WORD_MIN;
      return word_type'(v);
   endfunction

   function automatic word_type scaled_random();
      return word_type'($signed($urandom) >>> $urandom_range(1, 11));
   endfunction

   task automatic write_reg(logic [REG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_we <= 1'b1;
      @(posedge clock);
   endtask

   task automatic program_regs(word_type k0, word_type k1, word_type k2, word_type k3,
                               logic [WORD_BITS-1:0] tol_word, bit with_spare);
      write_reg(REG_COEF_CONST, k0);
      write_reg(REG_COEF_LINEAR, k1);
      write_reg(REG_COEF_SQUARE, k2);
      write_reg(REG_COEF_CUBE, k3);
      write_reg(REG_TOLERANCE, tol_word);
      if (with_spare) begin
         for (int i = REG_TOLERANCE + 1; i < (1 << REG_INDEX_BITS); i++) begin
            write_reg(i[REG_INDEX_BITS-1:0], $urandom);
         end
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_interval(word_type lo, word_type hi);
      if (!quiet && req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         req_bus.interval_low <= $urandom;
         req_bus.interval_high <= $urandom;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.interval_low <= lo;
      req_bus.interval_high <= hi;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic apply_setting(setting_kind_type kind);
      logic [WORD_BITS-1:0] tol_word;
      word_type k0;
      case ($urandom_range(0, 5))
         0: tol_word = '0;
         1: tol_word = $urandom;
         2: tol_word = '1;
         default: tol_word = (32'd1 << $urandom_range(0, 30)) - 1;
      endcase
      case (kind)
         SET_LINEAR_ROOT: begin
            k0 = scaled_random();
            linear_root = -longint'(k0);
            program_regs(k0, word_type'(UNIT), '0, '0, tol_word, $urandom_range(0, 1));
         end
         SET_MODERATE: begin
            program_regs(word_type'($signed($urandom) >>> $urandom_range(1, 12)),
                         word_type'($signed($urandom) >>> $urandom_range(1, 12)),
                         word_type'($signed($urandom) >>> $urandom_range(1, 12)),
                         word_type'($signed($urandom) >>> $urandom_range(1, 8)),
                         tol_word, $urandom_range(0, 1));
         end
         SET_WILD: begin
            program_regs($urandom, $urandom, $urandom, $urandom, tol_word, 1'b1);
         end
         default: begin
            program_regs(COEF_CONST_RESET, COEF_LINEAR_RESET, COEF_SQUARE_RESET,
                         COEF_CUBE_RESET, tol_word, 1'b0);
         end
      endcase
   endtask

   task automatic make_interval(setting_kind_type kind, output word_type lo,
                                output word_type hi);
      int roll;
      word_type swap_word;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         lo = $urandom;
         hi = $urandom;
      end else if (roll < 25) begin
         case ($urandom_range(0, 3))
            0: begin
               lo = $urandom;
               hi = lo;
            end
            1: begin
               lo = WORD_MIN;
               hi = WORD_MAX;
            end
            2: begin
               lo = '0;
               hi = $urandom;
            end
            default: begin
               lo = WORD_MAX;
               hi = WORD_MIN;
            end
         endcase
      end else begin
         if (kind == SET_LINEAR_ROOT) begin
            lo = fit_word(linear_root - 1 - longint'($urandom >> $urandom_range(1, 31)));
            hi = fit_word(linear_root + 1 + longint'($urandom >> $urandom_range(1, 31)));
         end else begin
            lo = word_type'(-longint'($urandom >> $urandom_range(1, 31)));
            hi = word_type'($urandom >> $urandom_range(1, 31));
         end
         if ($urandom_range(0, 5) == 0) begin
            swap_word = lo;
            lo = hi;
            hi = swap_word;
         end
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin : response_side
         int rsp_stall;
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall = LONG_HOLD;
         end else if (rsp_stall == 0 && !quiet && rsp_gap_odds != 0 &&
                      $urandom_range(1, rsp_gap_odds * 3) == 1) begin
            rsp_stall = $urandom_range(1, 17);
         end
         if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int sent;
      int phase;
      int phase_items;
      setting_kind_type kind;
      word_type lo;
      word_type hi;
      longint r;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.interval_low <= '0;
      req_bus.interval_high <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_interval('0, word_type'(UNIT));
      send_interval(word_type'(UNIT), '0);
      send_interval('0, word_type'(UNIT / 2));
      send_interval(word_type'(UNIT / 2), word_type'(3 * UNIT / 2));
      send_interval(word_type'(UNIT / 4), word_type'(UNIT / 4));
      send_interval(WORD_MIN, WORD_MAX);
      send_interval(WORD_MAX, WORD_MIN);
      send_interval('0, '0);
      wait_idle();

      r = 5 * UNIT / 4;
      program_regs(word_type'(-r), word_type'(UNIT), '0, '0, '0, 1'b0);
      send_interval(word_type'(r - 1000), word_type'(r + 1000));
      send_interval(word_type'(r - 12345), word_type'(r + 777));
      send_interval(word_type'(r), word_type'(r + 1000));
      send_interval(WORD_MIN, WORD_MAX);
      wait_idle();

      program_regs(word_type'(-r), word_type'(UNIT), '0, '0, '1, 1'b0);
      send_interval(word_type'(r - UNIT), word_type'(r + UNIT));
      send_interval(WORD_MIN, WORD_MAX);
      wait_idle();

      program_regs(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 32'd1, 1'b1);
      send_interval(WORD_MIN, WORD_MAX);
      send_interval(word_type'(-UNIT), word_type'(UNIT));
      send_interval(WORD_MAX, word_type'(-1));
      send_interval(word_type'(-1), word_type'(1));
      wait_idle();

      program_regs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0, 1'b0);
      send_interval(WORD_MIN, WORD_MAX);
      send_interval(word_type'(-2), word_type'(1));
      wait_idle();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         phase++;
         req_gap_odds = $urandom_range(0, 6);
         rsp_gap_odds = $urandom_range(0, 6);
         kind = setting_kind_type'($urandom_range(SET_LINEAR_ROOT, SET_DEFAULT));
         apply_setting(kind);
         if (phase == HOLD_PHASE) hold_request = 1'b1;
         phase_items = $urandom_range(50, 110);
         for (int n = 0; n < phase_items && sent < RANDOM_ITEMS; n++) begin
            quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
            make_interval(kind, lo, hi);
            send_interval(lo, hi);
            sent++;
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (mismatch_total == 0 && awaiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
